[rtl/dda_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dda_pkg: shared types and constants
// Coordinate width, input/output words, controller states and the
// command/status groups between controller and datapath.
// ----------------------------------------------------------------------------
package dda_pkg;

    localparam int CoordBits = 6;

    typedef logic [CoordBits-1:0] t_coord;

    typedef struct packed {
        t_coord start_x;
        t_coord start_y;
        t_coord end_x;
        t_coord end_y;
    } t_seg;

    typedef struct packed {
        t_coord pixel_x;
        t_coord pixel_y;
        logic   last_point;
    } t_point;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
    } t_cmd;

    typedef struct packed {
        logic zero_len;  // segment on input has equal endpoints
        logic last;      // current point is the final one
    } t_status;

endpackage

[rtl/dda_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dda_datapath: span setup and per-axis remainder walk
// Loads a segment, then advances both axes one point per step using an
// integer remainder against the major span instead of a division.
// ----------------------------------------------------------------------------
module dda_datapath
    import dda_pkg::*;
(
    input  logic    i_clk,
    input  t_seg    i_seg,
    input  t_cmd    i_cmd,
    output t_status o_status,
    output t_point  o_point
);

    localparam int SumBits = CoordBits + 1;

    t_coord r_pos_x, r_pos_y, n_pos_x, n_pos_y;
    t_coord r_rem_x, r_rem_y, n_rem_x, n_rem_y;
    t_coord r_ax, r_ay, r_span, r_cnt;
    logic   r_neg_x, r_neg_y;

    // setup from the input word
    logic   neg_x, neg_y;
    t_coord ax, ay, span;

    logic [SumBits-1:0] sum_x, sum_y;

    always_comb begin
        neg_x = i_seg.end_x < i_seg.start_x;
        neg_y = i_seg.end_y < i_seg.start_y;
        ax    = neg_x ? t_coord'(i_seg.start_x - i_seg.end_x)
                      : t_coord'(i_seg.end_x - i_seg.start_x);
        ay    = neg_y ? t_coord'(i_seg.start_y - i_seg.end_y)
                      : t_coord'(i_seg.end_y - i_seg.start_y);
        span  = (ax > ay) ? ax : ay;
    end

    // remainder update: |d| <= span, so one compare and subtract suffices
    always_comb begin
        sum_x   = {1'b0, r_rem_x} + {1'b0, r_ax};
        sum_y   = {1'b0, r_rem_y} + {1'b0, r_ay};
        n_rem_x = sum_x[CoordBits-1:0];
        n_rem_y = sum_y[CoordBits-1:0];
        n_pos_x = r_pos_x;
        n_pos_y = r_pos_y;
        if (sum_x >= {1'b0, r_span}) begin
            n_rem_x = t_coord'(sum_x - {1'b0, r_span});
            n_pos_x = r_neg_x ? t_coord'(r_pos_x - 1'b1) : t_coord'(r_pos_x + 1'b1);
        end
        if (sum_y >= {1'b0, r_span}) begin
            n_rem_y = t_coord'(sum_y - {1'b0, r_span});
            n_pos_y = r_neg_y ? t_coord'(r_pos_y - 1'b1) : t_coord'(r_pos_y + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pos_x <= i_seg.start_x;
            r_pos_y <= i_seg.start_y;
            r_rem_x <= '0;
            r_rem_y <= '0;
            r_ax    <= ax;
            r_ay    <= ay;
            r_span  <= span;
            r_neg_x <= neg_x;
            r_neg_y <= neg_y;
            r_cnt   <= '0;
        end else if (i_cmd.step) begin
            r_pos_x <= n_pos_x;
            r_pos_y <= n_pos_y;
            r_rem_x <= n_rem_x;
            r_rem_y <= n_rem_y;
            r_cnt   <= t_coord'(r_cnt + 1'b1);
        end
    end

    // negative direction: floor of a non-integer quotient is one further out
    always_comb begin
        o_status.last      = (r_cnt == t_coord'(r_span - 1'b1));
        o_status.zero_len  = (span == '0);
        o_point.pixel_x    = (r_neg_x && (r_rem_x != '0)) ? t_coord'(r_pos_x - 1'b1) : r_pos_x;
        o_point.pixel_y    = (r_neg_y && (r_rem_y != '0)) ? t_coord'(r_pos_y - 1'b1) : r_pos_y;
        o_point.last_point = (r_cnt == t_coord'(r_span - 1'b1));
    end

endmodule

[rtl/dda_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dda_ctrl: segment sequencer
// Accepts a segment when idle and steps the datapath once per point.
// ----------------------------------------------------------------------------
module dda_ctrl
    import dda_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy,
    output logic    o_point_valid
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_busy        = 1'b0;
        o_point_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.load = i_start;
                // zero-length segment produces nothing, stay idle
                if (i_start && !i_status.zero_len) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                o_busy        = 1'b1;
                o_point_valid = 1'b1;
                o_cmd.step    = 1'b1;
                if (i_status.last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/dda_line_rasterizer_core.sv]
`timescale 1ns / 1ps
// The first point is on o_point in the cycle after the segment is accepted.
// Points come out one per cycle while busy; a segment of s steps gives s points,
// and a new segment is accepted only once busy has dropped again.
// Equal endpoints: no points, busy stays low.
// Reset (synchronous, active low) returns the sequencer to idle.
// ----------------------------------------------------------------------------
// dda_line_rasterizer_core: DDA line rasterizer top level
// Walks a segment inside a square tile and strobes out each pixel point,
// excluding the end point, with the final one marked.
// ----------------------------------------------------------------------------
module dda_line_rasterizer_core
    import dda_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   start,
    input  t_seg   i_seg,
    output logic   busy,
    output logic   o_point_valid,
    output t_point o_point
);

    t_cmd    cmd;
    t_status status;

    dda_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_status      (status),
        .o_cmd         (cmd),
        .o_busy        (busy),
        .o_point_valid (o_point_valid)
    );

    dda_datapath u_datapath (
        .i_clk    (i_clk),
        .i_seg    (i_seg),
        .i_cmd    (cmd),
        .o_status (status),
        .o_point  (o_point)
    );

endmodule

[rtl/dda_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dda_checker: port-level checks
// Watches the top-level ports for sequencing of points against busy.
// ----------------------------------------------------------------------------
module dda_checker
    import dda_pkg::*;
(
    input logic   i_clk,
    input logic   i_rst_n,
    input logic   start,
    input t_seg   i_seg,
    input logic   busy,
    input logic   o_point_valid,
    input t_point o_point
);

    // points only come out while a segment is in flight
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_point_valid |-> busy)
        else $error("point word outside busy");

    // a non-final point is always followed by another point
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_point_valid && !o_point.last_point) |=> o_point_valid)
        else $error("gap inside segment");

    // the final point releases the block
    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_point_valid && o_point.last_point) |=> !busy)
        else $error("busy after last point");

    // a nonzero segment starts emitting on the next cycle
    a_first_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && ((i_seg.start_x != i_seg.end_x) ||
                            (i_seg.start_y != i_seg.end_y)))
        |=> (o_point_valid && (o_point.pixel_x == $past(i_seg.start_x))
             && (o_point.pixel_y == $past(i_seg.start_y))))
        else $error("first point missing or wrong");

    // equal endpoints produce nothing
    a_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_seg.start_x == i_seg.end_x) &&
         (i_seg.start_y == i_seg.end_y)) |=> !o_point_valid)
        else $error("point from zero-length segment");

endmodule

bind dda_line_rasterizer_core dda_checker u_dda_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .i_seg         (i_seg),
    .busy          (busy),
    .o_point_valid (o_point_valid),
    .o_point       (o_point)
);
